FILE: src/sfnv_pkg.sv
// Package for the seeded FNV-1a string hash unit.
// Holds the hash constants, the sequencer state type and the default seed.
// No dependencies.
package sfnv_pkg;

  localparam logic [31:0] HASH_PRIME = 32'h0100_0193;
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] SEED_RESET = 32'h0000_0000;

  // register index of the seed in the config map
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HI,
    ST_DONE
  } seq_state_t;

endpackage

FILE: src/seeded_fnv_string_hash_unit.sv
// Seeded FNV-1a hash over 16-bit character strings, one byte round per cycle unless stalled.
// Uses sfnv_pkg for constants and the sequencer state type.
//
//   channel | direction | ports                                          | handshake
//   in      | sink      | in_char_code, in_char_valid, in_last_char      | in_valid / in_stall
//   out     | source    | out_hash_value                                 | out_valid / out_stall
//   cfg     | slave     | psel penable pwrite paddr pwdata prdata pready | APB, pready tied high
//
// For a character the low-byte round runs in the transfer cycle, the high-byte round
// in the next, both through the one round unit (xor, constant multiply, fold). An idle
// item (no character, not last) changes nothing; a characterless end goes via ST_DONE.
// The hash waits in the output register; while that is still full a finished hash holds
// in the hash register and the input stays stalled.
// Reset (rst_n low, synchronous) clears the seed, closes any open string and drops out_valid.
module seeded_fnv_string_hash_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_char_code,
  input  logic        in_char_valid,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sfnv_pkg::seq_state_t state_r, state_nxt;

  logic [31:0] seed_r;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] pert_r, pert_nxt;
  logic        mid_r, mid_nxt;
  logic [7:0]  hi_byte_r, hi_byte_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic        in_xfer;
  logic        out_free;
  logic [31:0] open_hash;
  logic [31:0] open_pert;
  logic [31:0] rnd_hash_in;
  logic [31:0] rnd_pert_in;
  logic [7:0]  rnd_byte;
  logic [31:0] rnd_hash;
  logic [31:0] rnd_pert;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == sfnv_pkg::REG_SEED) ? seed_r : 32'h0;
  assign in_stall = (state_r != sfnv_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // a string opens with the basis and the seed
  assign open_hash = mid_r ? hash_r : sfnv_pkg::HASH_BASIS;
  assign open_pert = mid_r ? pert_r : seed_r;

  // shared round unit
  always_comb begin
    if (state_r == sfnv_pkg::ST_IDLE) begin
      rnd_hash_in = open_hash;
      rnd_pert_in = open_pert;
      rnd_byte    = in_char_code[7:0];
    end else begin
      rnd_hash_in = hash_r;
      rnd_pert_in = pert_r;
      rnd_byte    = hi_byte_r;
    end
    rnd_hash = 32'(((rnd_hash_in ^ {24'h0, rnd_byte ^ rnd_pert_in[7:0]}))
                   * sfnv_pkg::HASH_PRIME);
    rnd_pert = (rnd_pert_in ^ rnd_hash) >> 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= sfnv_pkg::SEED_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == sfnv_pkg::REG_SEED) begin
      seed_r <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfnv_pkg::ST_IDLE;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
      hash_r      <= sfnv_pkg::HASH_BASIS;
      pert_r      <= 32'h0;
    end else begin
      state_r     <= state_nxt;
      mid_r       <= mid_nxt;
      out_valid_r <= out_valid_nxt;
      hash_r      <= hash_nxt;
      pert_r      <= pert_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_byte_r  <= hi_byte_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mid_nxt       = mid_r;
    hash_nxt      = hash_r;
    pert_nxt      = pert_r;
    hi_byte_nxt   = hi_byte_r;
    last_nxt      = last_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      sfnv_pkg::ST_IDLE: begin
        if (in_xfer && (in_char_valid || in_last_char)) begin
          mid_nxt  = 1'b1;
          last_nxt = in_last_char;
          if (in_char_valid) begin
            hash_nxt    = rnd_hash;
            pert_nxt    = rnd_pert;
            hi_byte_nxt = in_char_code[15:8];
            state_nxt   = sfnv_pkg::ST_HI;
          end else begin
            hash_nxt  = open_hash;
            pert_nxt  = open_pert;
            state_nxt = sfnv_pkg::ST_DONE;
          end
        end
      end
      sfnv_pkg::ST_HI: begin
        hash_nxt = rnd_hash;
        pert_nxt = rnd_pert;
        if (!last_r) begin
          state_nxt = sfnv_pkg::ST_IDLE;
        end else if (out_free) begin
          out_hash_nxt  = rnd_hash;
          out_valid_nxt = 1'b1;
          mid_nxt       = 1'b0;
          state_nxt     = sfnv_pkg::ST_IDLE;
        end else begin
          state_nxt = sfnv_pkg::ST_DONE;
        end
      end
      sfnv_pkg::ST_DONE: begin
        if (out_free) begin
          out_hash_nxt  = hash_r;
          out_valid_nxt = 1'b1;
          mid_nxt       = 1'b0;
          state_nxt     = sfnv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sfnv_pkg::ST_IDLE;
      end
    endcase
  end

  a_char_goes_hi: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_char_valid |=> state_r == sfnv_pkg::ST_HI)
    else $error("character transfer did not start the high-byte round");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      ($past(state_r) == sfnv_pkg::ST_HI || $past(state_r) == sfnv_pkg::ST_DONE))
    else $error("result raised outside a finishing state");

  a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(mid_r) |-> out_valid_r && $past(last_r))
    else $error("string closed without a result");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sfnv_pkg::ST_DONE && out_valid_r && out_stall |=>
      state_r == sfnv_pkg::ST_DONE)
    else $error("pending result left while output full");

endmodule
